// ===== rtl/brf_pkg.sv =====
// Shared constants and types of the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

   localparam int MEM_BYTES      = 1024;
   localparam int ITEM_MAX_BYTES = 64;

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int IB_W   = 7;
   localparam int CNT_W  = $clog2(ITEM_MAX_BYTES);

   localparam logic OP_SEND = 1'b0;
   localparam logic OP_RECV = 1'b1;

   typedef struct packed {
      logic       is_receive;
      logic       failed;
      logic [7:0] out_byte;
      logic       last;
      logic       is_full;
      logic       is_empty;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_fifo_unit.sv =====
// Top level of the byte ring FIFO: controller, byte memory and result queue.
// Send bytes are taken one per cycle while req_tready is high; a send's status
// result passes the stage register and the result queue. A receive blocks
// requests while it issues one memory read per byte; its bytes pass the stage
// register and the result queue, one per cycle while the response side is ready.
// Synchronous reset clears pointers and sets the item size to one byte; the
// byte memory is not cleared and holds nothing valid until written.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_unit (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [6:0]  csr_data,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [7:0] data_byte
   input  wire        req_tuser,   // [0] op
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata,  // [0] failed, [8:1] out_byte, [9] is_full,
                                   // [10] is_empty, [15:11] zero
   output logic       rsp_tuser,   // [0] is_receive
   output logic       rsp_tlast
);

   brf_pkg::push_type                push;
   brf_pkg::rsp_type                 rsp;
   logic                             credit;
   logic                             ram_we;
   logic                             ram_re;
   logic [brf_pkg::ADDR_W-1:0]       ram_waddr;
   logic [brf_pkg::ADDR_W-1:0]       ram_raddr;
   logic [7:0]                       ram_wdata;
   logic [7:0]                       ram_rdata;

   assign csr_ready = 1'b1;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_byte  (req_tdata),
      .credit    (credit),
      .push      (push),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   brf_ram #(
      .WIDTH (8),
      .DEPTH (brf_pkg::MEM_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   brf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .credit    (credit),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp)
   );

   assign rsp_tdata = {5'b00000, rsp.is_empty, rsp.is_full, rsp.out_byte, rsp.failed};
   assign rsp_tuser = rsp.is_receive;
   assign rsp_tlast = rsp.last;

endmodule

`default_nettype wire

// ===== rtl/brf_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/brf_rsp_fifo.sv =====
// Two-entry result queue that decouples the controller from the response channel.
`timescale 1ns / 1ps
`default_nettype none

module brf_rsp_fifo (
   input  wire               clock,
   input  wire               reset,
   input  brf_pkg::push_type push,
   output logic              credit,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output brf_pkg::rsp_type  rsp_data
);

   brf_pkg::rsp_type entry_ff [2];
   logic [1:0] level_ff, level_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       pop;
   logic [2:0] level_next;

   assign rsp_valid = (level_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Room is counted with the entry about to be pushed, so a new result may
   // only be started when it is sure to find a place.
   assign level_next = {1'b0, level_ff} + {2'b00, push.valid} - {2'b00, pop};
   assign credit     = (level_next < 3'd2);

   always_comb begin
      level_in  = level_next[1:0];
      wr_ptr_in = push.valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.rsp;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/brf_ctrl.sv =====
// Slot pointers, send run tracking and the receive read sequencer.
`timescale 1ns / 1ps
`default_nettype none

module brf_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_valid,
   input  wire [brf_pkg::IB_W-1:0]     csr_data,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_op,
   input  wire [7:0]                   req_byte,
   input  wire                         credit,
   output brf_pkg::push_type           push,
   output logic                        ram_we,
   output logic [brf_pkg::ADDR_W-1:0]  ram_waddr,
   output logic [7:0]                  ram_wdata,
   output logic                        ram_re,
   output logic [brf_pkg::ADDR_W-1:0]  ram_raddr,
   input  wire  [7:0]                  ram_rdata
);

   localparam int AW = brf_pkg::ADDR_W;
   localparam int IW = brf_pkg::IB_W;
   localparam int CW = brf_pkg::CNT_W;

   logic [IW-1:0] ib_ff, ib_in;
   logic [AW-1:0] wbase_ff, wbase_in;
   logic [AW-1:0] rbase_ff, rbase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rej_ff, rej_in;
   logic          rx_busy_ff, rx_busy_in;
   logic [AW-1:0] rx_addr_ff, rx_addr_in;
   logic [CW-1:0] rx_cnt_ff, rx_cnt_in;
   logic          rx_full_ff, rx_full_in;
   logic          rx_empty_ff, rx_empty_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ram_ff, s1_ram_in;
   brf_pkg::rsp_type s1_rsp_ff, s1_rsp_in;

   logic [AW-1:0] wnext, wnext2, rnext;
   logic          full_now, empty_now;
   logic          accept, rej_cur, last_byte, issue, rx_last;
   logic [IW-1:0] ib_clamped;

   // The slot after base begins one item further on; it wraps to zero when
   // the following item would no longer fit, which matches modulo capacity.
   function automatic logic [AW-1:0] next_base(input logic [AW-1:0] b,
                                               input logic [IW-1:0] ib);
      logic [AW:0]   sum;
      logic [AW+1:0] reach;
      sum   = {1'b0, b} + (AW+1)'(ib);
      reach = {1'b0, sum} + (AW+2)'(ib);
      if (reach > (AW+2)'(brf_pkg::MEM_BYTES)) begin
         return '0;
      end
      return sum[AW-1:0];
   endfunction

   assign wnext     = next_base(wbase_ff, ib_ff);
   assign wnext2    = next_base(wnext, ib_ff);
   assign rnext     = next_base(rbase_ff, ib_ff);
   assign full_now  = (wnext == rbase_ff);
   assign empty_now = (wbase_ff == rbase_ff);

   assign req_ready = !rx_busy_ff && credit;
   assign accept    = req_valid && req_ready;

   assign rej_cur   = (cnt_ff == '0) ? full_now : rej_ff;
   assign last_byte = ({1'b0, cnt_ff} == ib_ff - IW'(1));

   assign ram_we    = accept && (req_op == brf_pkg::OP_SEND) && !rej_cur;
   assign ram_waddr = wbase_ff + AW'(cnt_ff);
   assign ram_wdata = req_byte;

   assign issue     = rx_busy_ff && credit;
   assign rx_last   = ({1'b0, rx_cnt_ff} == ib_ff - IW'(1));
   assign ram_re    = issue;
   assign ram_raddr = rx_addr_ff + AW'(rx_cnt_ff);

   always_comb begin
      if (csr_data == '0) begin
         ib_clamped = IW'(1);
      end else if (csr_data > IW'(brf_pkg::ITEM_MAX_BYTES)) begin
         ib_clamped = IW'(brf_pkg::ITEM_MAX_BYTES);
      end else begin
         ib_clamped = csr_data;
      end
   end

   always_comb begin
      ib_in       = ib_ff;
      wbase_in    = wbase_ff;
      rbase_in    = rbase_ff;
      cnt_in      = cnt_ff;
      rej_in      = rej_ff;
      rx_busy_in  = rx_busy_ff;
      rx_addr_in  = rx_addr_ff;
      rx_cnt_in   = rx_cnt_ff;
      rx_full_in  = rx_full_ff;
      rx_empty_in = rx_empty_ff;
      s1_valid_in = 1'b0;
      s1_ram_in   = 1'b0;
      s1_rsp_in   = s1_rsp_ff;

      if (csr_valid) begin
         ib_in    = ib_clamped;
         wbase_in = '0;
         rbase_in = '0;
         cnt_in   = '0;
         rej_in   = 1'b0;
      end else if (accept && (req_op == brf_pkg::OP_SEND)) begin
         if (last_byte) begin
            cnt_in               = '0;
            rej_in               = 1'b0;
            s1_valid_in          = 1'b1;
            s1_rsp_in.is_receive = 1'b0;
            s1_rsp_in.failed     = rej_cur;
            s1_rsp_in.out_byte   = 8'h00;
            s1_rsp_in.last       = 1'b1;
            if (rej_cur) begin
               s1_rsp_in.is_full  = full_now;
               s1_rsp_in.is_empty = empty_now;
            end else begin
               wbase_in           = wnext;
               s1_rsp_in.is_full  = (wnext2 == rbase_ff);
               s1_rsp_in.is_empty = (wnext == rbase_ff);
            end
         end else begin
            cnt_in = cnt_ff + CW'(1);
            rej_in = rej_cur;
         end
      end else if (accept) begin
         if (empty_now) begin
            s1_valid_in          = 1'b1;
            s1_rsp_in.is_receive = 1'b1;
            s1_rsp_in.failed     = 1'b1;
            s1_rsp_in.out_byte   = 8'h00;
            s1_rsp_in.last       = 1'b1;
            s1_rsp_in.is_full    = full_now;
            s1_rsp_in.is_empty   = 1'b1;
         end else begin
            rbase_in    = rnext;
            rx_busy_in  = 1'b1;
            rx_addr_in  = rbase_ff;
            rx_cnt_in   = '0;
            rx_full_in  = (wnext == rnext);
            rx_empty_in = (wbase_ff == rnext);
         end
      end else if (issue) begin
         s1_valid_in          = 1'b1;
         s1_ram_in            = 1'b1;
         s1_rsp_in.is_receive = 1'b1;
         s1_rsp_in.failed     = 1'b0;
         s1_rsp_in.out_byte   = 8'h00;
         s1_rsp_in.last       = rx_last;
         s1_rsp_in.is_full    = rx_full_ff;
         s1_rsp_in.is_empty   = rx_empty_ff;
         rx_cnt_in            = rx_cnt_ff + CW'(1);
         if (rx_last) begin
            rx_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ib_ff       <= IW'(1);
         wbase_ff    <= '0;
         rbase_ff    <= '0;
         cnt_ff      <= '0;
         rej_ff      <= 1'b0;
         rx_busy_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         ib_ff       <= ib_in;
         wbase_ff    <= wbase_in;
         rbase_ff    <= rbase_in;
         cnt_ff      <= cnt_in;
         rej_ff      <= rej_in;
         rx_busy_ff  <= rx_busy_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_addr_ff  <= rx_addr_in;
      rx_cnt_ff   <= rx_cnt_in;
      rx_full_ff  <= rx_full_in;
      rx_empty_ff <= rx_empty_in;
      s1_ram_ff   <= s1_ram_in;
      s1_rsp_ff   <= s1_rsp_in;
   end

   // Receive bytes pick up the memory read data as they leave the stage.
   always_comb begin
      push.valid        = s1_valid_ff;
      push.rsp          = s1_rsp_ff;
      push.rsp.out_byte = s1_ram_ff ? ram_rdata : 8'h00;
   end

endmodule

`default_nettype wire

// ===== tb/tb_byte_ring_fifo_unit.sv =====
// Self-checking testbench of the byte ring FIFO unit: driver, monitor and FIFO predictor.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_unit;

   localparam int   MEM_BYTES      = brf_pkg::MEM_BYTES;
   localparam int   ITEM_MAX_BYTES = brf_pkg::ITEM_MAX_BYTES;
   localparam int   ADDR_W         = brf_pkg::ADDR_W;
   localparam int   IB_W           = brf_pkg::IB_W;
   localparam logic OP_SEND        = brf_pkg::OP_SEND;
   localparam logic OP_RECV        = brf_pkg::OP_RECV;

   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 10;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = OP_SEND;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   byte_ring_fifo_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Mirror of the ring: byte memory, slot pointers, item size and the send run in progress.
   logic [7:0]        mirror_mem [MEM_BYTES];
   logic [ADDR_W-1:0] head_slot;
   logic [ADDR_W-1:0] tail_slot;
   logic [ADDR_W:0]   slot_total;
   logic [IB_W-1:0]   item_len;
   logic [IB_W-1:0]   run_count;
   logic              run_dropped;

   brf_pkg::rsp_type due_results[$];
   req_item_type     queued_reqs[$];
   int        reqs_issued = 0;
   int        reqs_taken = 0;
   int        results_seen = 0;
   int        fault_count = 0;
   bit        req_idling = 1'b1;
   bit        rsp_idling = 1'b1;
   int        req_gap = 0;
   int        rsp_wait = 0;
   int        hold_cycles = 0;
   int        holds_asked = 0;
   int        holds_done = 0;
   int        quiet_cycles = 0;

   function automatic logic [ADDR_W-1:0] slot_after(input logic [ADDR_W-1:0] s);
      return ADDR_W'((int'(s) + 1) % int'(slot_total));
   endfunction

   function automatic bit ring_full();
      return slot_after(head_slot) == tail_slot;
   endfunction

   function automatic bit ring_empty();
      return head_slot == tail_slot;
   endfunction

   function automatic string describe_result(input brf_pkg::rsp_type r);
      return $sformatf("rx=%0b fail=%0b byte=%02h last=%0b full=%0b empty=%0b",
                       r.is_receive, r.failed, r.out_byte, r.last, r.is_full, r.is_empty);
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   task automatic push_result(input logic rx, input logic fail, input logic [7:0] b,
                              input logic fin);
      brf_pkg::rsp_type r;
      r.is_receive = rx;
      r.failed     = fail;
      r.out_byte   = b;
      r.last       = fin;
      r.is_full    = ring_full();
      r.is_empty   = ring_empty();
      due_results.push_back(r);
   endtask

   task automatic set_item_size(input logic [IB_W-1:0] v);
      logic [IB_W-1:0] n;
      n = v;
      if (n == 0) begin
         n = 1;
      end
      if (n > ITEM_MAX_BYTES) begin
         n = IB_W'(ITEM_MAX_BYTES);
      end
      item_len    = n;
      slot_total  = (ADDR_W + 1)'(MEM_BYTES / int'(n));
      head_slot   = '0;
      tail_slot   = '0;
      run_count   = '0;
      run_dropped = 1'b0;
   endtask

   // Works out the results that one accepted request causes and updates the mirror.
   task automatic apply_fifo_request(input logic op, input logic [7:0] data);
      int   addr;
      int   base;
      logic fail;
      if (op == OP_SEND) begin
         // The accept decision is taken at the first byte and holds for the whole run.
         if (run_count == 0) begin
            run_dropped = ring_full();
         end
         if (!run_dropped) begin
            addr = int'(head_slot) * int'(item_len) + int'(run_count);
            if (addr < MEM_BYTES) begin
               mirror_mem[addr] = data;
            end
         end
         run_count = run_count + 1;
         if (run_count == item_len) begin
            fail = run_dropped;
            if (!fail) begin
               head_slot = slot_after(head_slot);
            end
            run_count   = '0;
            run_dropped = 1'b0;
            push_result(1'b0, fail, 8'h00, 1'b1);
         end
      end else if (ring_empty()) begin
         push_result(1'b1, 1'b1, 8'h00, 1'b1);
      end else begin
         base      = int'(tail_slot) * int'(item_len);
         tail_slot = slot_after(tail_slot);
         for (int i = 0; i < int'(item_len); i++) begin
            push_result(1'b1, 1'b0, mirror_mem[base + i], (i + 1) == int'(item_len));
         end
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_fifo_request(req_tuser, req_tdata);
            reqs_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (queued_reqs.size() != 0) begin
               nxt = queued_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= nxt.data;
               req_gap = req_idling ? int'($urandom_range(0, 10)) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started on demand from the stimulus.
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (holds_done != holds_asked) begin
         hold_cycles <= HOLD_CYCLES;
         holds_done  <= holds_done + 1;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      brf_pkg::rsp_type got;
      brf_pkg::rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_receive = rsp_tuser;
            got.failed     = rsp_tdata[0];
            got.out_byte   = rsp_tdata[8:1];
            got.last       = rsp_tlast;
            got.is_full    = rsp_tdata[9];
            got.is_empty   = rsp_tdata[10];
            if (due_results.size() == 0) begin
               note_fault($sformatf("result %0d arrived with nothing pending: %s",
                                    results_seen, describe_result(got)));
            end else begin
               want = due_results.pop_front();
               if (got.is_receive !== want.is_receive || got.failed !== want.failed ||
                   got.out_byte !== want.out_byte || got.last !== want.last ||
                   got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
                  note_fault($sformatf("result %0d mismatch: expected %s, got %s",
                                       results_seen, describe_result(want),
                                       describe_result(got)));
               end
            end
            results_seen++;
            rsp_wait = rsp_idling ? int'($urandom_range(0, 10)) : 0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0) && (hold_cycles == 0);
      end
   end

   // Watchdog on cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[%0t] timeout: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("byte_ring_fifo_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_req(input logic op, input logic [7:0] data);
      req_item_type it;
      it.op   = op;
      it.data = data;
      queued_reqs.push_back(it);
      reqs_issued++;
   endtask

   task automatic queue_send(input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         queue_req(OP_SEND, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic queue_recv();
      queue_req(OP_RECV, 8'($urandom_range(0, 255)));
   endtask

   // Waits until every request is taken and every result is in, then for the pipeline to drain.
   task automatic settle();
      while (reqs_taken != reqs_issued) begin
         @(posedge clock);
      end
      while (due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_item_size(input logic [6:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      set_item_size(v);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_start;
      int pick;
      set_item_size(1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Item size one after reset: empty receive, extreme bytes, drain to empty.
      queue_recv();
      queue_req(OP_SEND, 8'h00);
      queue_req(OP_SEND, 8'hFF);
      queue_req(OP_SEND, 8'hA5);
      repeat (4) queue_recv();

      // A receive in the middle of a send run; the run carries on afterwards.
      write_item_size(7'd3);
      queue_req(OP_SEND, 8'h01);
      queue_req(OP_SEND, 8'h80);
      queue_req(OP_SEND, 8'h7F);
      queue_req(OP_SEND, 8'hFE);
      queue_recv();
      queue_req(OP_SEND, 8'h55);
      queue_req(OP_SEND, 8'hAA);
      queue_recv();
      queue_recv();

      // A partial run is abandoned by the size write; zero is taken as one.
      queue_send(2);
      write_item_size(7'd0);
      queue_send(1);
      queue_recv();

      // Size above the maximum gives the largest items; a receive on the empty ring
      // interrupts the run, which still commits.
      write_item_size(7'd127);
      req_idling = 1'b0;
      queue_send(10);
      queue_recv();
      queue_send(int'(item_len) - 10);
      queue_recv();
      queue_recv();

      // The receiver holds off while requests keep coming, so the unit backs up.
      write_item_size(7'd6);
      repeat (3) queue_send(int'(item_len));
      holds_asked++;
      repeat (3) queue_recv();
      repeat (2) queue_send(int'(item_len));
      repeat (3) queue_recv();

      // Random phases over a spread of item sizes, mostly whole items and receives.
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: write_item_size(7'd2);
            1: write_item_size(7'd5);
            2: write_item_size(7'd8);
            3: write_item_size(7'd16);
            4: write_item_size(7'd3);
            5: write_item_size(7'd7);
            6: write_item_size(7'd1);
            default: write_item_size(7'd4);
         endcase
         req_idling  = (k % 3) != 0;
         rsp_idling  = (k % 3) != 1;
         phase_start = reqs_issued;
         while (reqs_issued - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               queue_send(int'(item_len));
            end else if (pick < 9) begin
               queue_recv();
            end else begin
               queue_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end
      end

      settle();
      if (fault_count == 0 && due_results.size() == 0) begin
         $display("byte_ring_fifo_unit verification clean");
      end else begin
         $display("byte_ring_fifo_unit verification failed");
      end
      $finish;
   end

endmodule
